// ===== sv/first_fit_block_allocator_top_macros.svh =====
// assertion macros for the first-fit allocator rtl
// no dependencies; included by ffba_ctrl, the file that carries assertions
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// condition must hold at every edge out of reset
`define FFBA_ASSERT_ALW(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FFBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/ffba_pkg.sv =====
// shared types, codes and reset values of the first-fit block allocator
// no dependencies
package ffba_pkg;

    localparam int MAX_BLOCKS_DEF = 64;

    localparam int SIZE_W  = 27;
    localparam int ADDR_W  = 32;
    localparam int HDR_W   = 7;
    localparam int TYPE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int HNDL_W  = 6;
    localparam int CNT_W   = 7;
    localparam int CFGI_W  = 2;
    localparam int CFGD_W  = 32;

    // request types
    localparam logic [TYPE_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE    = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_REALLOC = 2'd2;

    // result status
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SIZE    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADHNDL = 2'd3;

    // configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_MAX_REQUEST  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_HEAP_LIMIT   = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_HEADER_BYTES = 2'd2;

    localparam logic [SIZE_W-1:0] MAX_REQUEST_RST  = 27'd100000000;
    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST   = 32'hFFFF_FFFF;
    localparam logic [HDR_W-1:0]  HEADER_BYTES_RST = 7'd32;

    // search token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [SIZE_W-1:0] fit_size;
        logic [ADDR_W-1:0] fit_offset;
        logic [SIZE_W-1:0] hnd_size;
        logic [ADDR_W-1:0] hnd_offset;
        logic              hnd_free;
    } t_tok;

    // request broadcast to all cells during a scan
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              hnd_en;
    } t_req;

    // table update broadcast at the end of a scan
    typedef struct packed {
        logic              new_en;
        logic [SIZE_W-1:0] new_size;
        logic [ADDR_W-1:0] new_offset;
        logic              take_en;
        logic              free_en;
    } t_wr;

endpackage

// ===== sv/ffba_cell.sv =====
// one table entry of the allocator plus one stage of the search token chain
// depends on ffba_pkg
module ffba_cell #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int CELL_ID    = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ffba_pkg::t_tok                    i_tok,
    input  logic [$clog2(MAX_BLOCKS)-1:0]     i_fit_idx,
    output ffba_pkg::t_tok                    o_tok,
    output logic [$clog2(MAX_BLOCKS)-1:0]     o_fit_idx,
    input  ffba_pkg::t_req                    i_req,
    input  logic [$clog2(MAX_BLOCKS)-1:0]     i_hnd_idx,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]   i_count,
    input  ffba_pkg::t_wr                     i_wr,
    input  logic [$clog2(MAX_BLOCKS)-1:0]     i_take_idx
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS+1);
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_ID);
    localparam logic [CW-1:0] MY_POS = CW'(CELL_ID);

    logic [ffba_pkg::SIZE_W-1:0] r_size;
    logic [ffba_pkg::ADDR_W-1:0] r_offset;
    logic                        r_free;

    ffba_pkg::t_tok  r_tok, n_tok;
    logic [IW-1:0]   r_fit_idx, n_fit_idx;

    logic live, fit_here, hnd_here;

    assign live     = MY_POS < i_count;
    assign fit_here = live && r_free && (r_size >= i_req.size);
    assign hnd_here = i_req.hnd_en && (i_hnd_idx == MY_IDX);

    always_comb begin
        n_tok     = i_tok;
        n_fit_idx = i_fit_idx;
        // first fit wins: later cells keep what an earlier one found
        if (!i_tok.found && fit_here) begin
            n_tok.found      = 1'b1;
            n_tok.fit_size   = r_size;
            n_tok.fit_offset = r_offset;
            n_fit_idx        = MY_IDX;
        end
        if (hnd_here) begin
            n_tok.hnd_size   = r_size;
            n_tok.hnd_offset = r_offset;
            n_tok.hnd_free   = r_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok     <= '0;
            r_fit_idx <= '0;
        end else begin
            r_tok     <= n_tok;
            r_fit_idx <= n_fit_idx;
        end
    end

    // entry storage, valid only below the block count
    always_ff @(posedge i_clk) begin
        if (i_wr.new_en && (i_count == MY_POS)) begin
            r_size   <= i_wr.new_size;
            r_offset <= i_wr.new_offset;
            r_free   <= 1'b0;
        end
        if (i_wr.take_en && (i_take_idx == MY_IDX)) begin
            r_free <= 1'b0;
        end
        if (i_wr.free_en && (i_hnd_idx == MY_IDX)) begin
            r_free <= 1'b1;
        end
    end

    assign o_tok     = r_tok;
    assign o_fit_idx = r_fit_idx;

endmodule

// ===== sv/ffba_ctrl.sv =====
// request sequencer of the allocator: config registers, counters, decision, result
// depends on ffba_pkg and first_fit_block_allocator_top_macros.svh
`include "first_fit_block_allocator_top_macros.svh"

module ffba_ctrl #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [ffba_pkg::TYPE_W-1:0]       i_req_type,
    input  logic [ffba_pkg::SIZE_W-1:0]       i_req_size,
    input  logic [ffba_pkg::HNDL_W-1:0]       i_block_index,
    input  logic                              i_has_block,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ffba_pkg::CFGI_W-1:0]       i_cfg_index,
    input  logic [ffba_pkg::CFGD_W-1:0]       i_cfg_data,
    output ffba_pkg::t_tok                    o_head,
    output ffba_pkg::t_req                    o_req,
    output logic [$clog2(MAX_BLOCKS)-1:0]     o_hnd_idx,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]   o_count,
    output ffba_pkg::t_wr                     o_wr,
    output logic [$clog2(MAX_BLOCKS)-1:0]     o_take_idx,
    input  ffba_pkg::t_tok                    i_tail,
    input  logic [$clog2(MAX_BLOCKS)-1:0]     i_tail_idx,
    output logic                              o_done,
    output logic [ffba_pkg::STAT_W-1:0]       o_status,
    output logic [ffba_pkg::HNDL_W-1:0]       o_result_index,
    output logic [ffba_pkg::ADDR_W-1:0]       o_payload_offset,
    output logic                              o_reused,
    output logic [ffba_pkg::SIZE_W-1:0]       o_copy_bytes,
    output logic [ffba_pkg::CNT_W-1:0]        o_free_blocks,
    output logic [ffba_pkg::ADDR_W-1:0]       o_free_bytes,
    output logic [ffba_pkg::CNT_W-1:0]        o_alloc_blocks,
    output logic [ffba_pkg::ADDR_W-1:0]       o_alloc_bytes
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS+1);
    localparam int SW = ffba_pkg::SIZE_W;
    localparam int AW = ffba_pkg::ADDR_W;
    localparam int EW = AW + 2;
    localparam logic [CW-1:0] FULL = CW'(MAX_BLOCKS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic r_state, n_state;
    logic r_launch;
    logic r_done;

    logic [SW-1:0]               r_max_request;
    logic [AW-1:0]               r_heap_limit;
    logic [ffba_pkg::HDR_W-1:0]  r_header_bytes;

    logic [CW-1:0] r_count;
    logic [AW-1:0] r_heap_top;
    logic [CW-1:0] r_free_blocks;
    logic [AW-1:0] r_free_bytes;
    logic [AW-1:0] r_alloc_bytes;

    // request held for the whole scan
    logic [ffba_pkg::TYPE_W-1:0] r_type;
    logic [SW-1:0]               r_size;
    logic                        r_has;
    logic                        r_hvalid;
    logic [IW-1:0]               r_hnd_idx;

    // result payload
    logic [ffba_pkg::STAT_W-1:0] r_status;
    logic [IW-1:0]               r_idx;
    logic [AW-1:0]               r_off;
    logic                        r_reuse;
    logic [SW-1:0]               r_copy;

    logic accept, fire;

    logic          size_bad;
    logic [EW-1:0] end_sum;
    logic [ffba_pkg::STAT_W-1:0] a_status;
    logic          a_ok, a_reuse, a_new;
    logic [IW-1:0] a_idx;
    logic [AW-1:0] a_off;

    logic [ffba_pkg::STAT_W-1:0] d_status;
    logic          d_give, d_reuse, d_take, d_new, d_free;
    logic [IW-1:0] d_idx;
    logic [AW-1:0] d_off;
    logic [SW-1:0] d_copy;

    assign accept = i_start && (r_state == ST_IDLE);
    assign fire   = (r_state == ST_SCAN) && i_tail.valid;

    // allocation outcome, shared by allocate and reallocate
    always_comb begin
        size_bad = (r_size == '0) || (r_size > r_max_request);
        end_sum  = EW'(r_heap_top) + EW'(r_header_bytes) + EW'(r_size);
        a_status = ffba_pkg::STAT_OK;
        a_ok     = 1'b0;
        a_reuse  = 1'b0;
        a_new    = 1'b0;
        a_idx    = '0;
        a_off    = '0;
        if (size_bad) begin
            a_status = ffba_pkg::STAT_SIZE;
        end else if (i_tail.found) begin
            a_ok    = 1'b1;
            a_reuse = 1'b1;
            a_idx   = i_tail_idx;
            a_off   = i_tail.fit_offset;
        end else if (r_count >= FULL) begin
            a_status = ffba_pkg::STAT_NOSPACE;
        end else if (end_sum > EW'(r_heap_limit)) begin
            a_status = ffba_pkg::STAT_NOSPACE;
        end else begin
            a_ok  = 1'b1;
            a_new = 1'b1;
            a_idx = IW'(r_count);
            a_off = r_heap_top + AW'(r_header_bytes);
        end
    end

    // request decode
    always_comb begin
        d_status = ffba_pkg::STAT_OK;
        d_give   = 1'b0;
        d_reuse  = 1'b0;
        d_take   = 1'b0;
        d_new    = 1'b0;
        d_free   = 1'b0;
        d_idx    = '0;
        d_off    = '0;
        d_copy   = '0;
        unique case (r_type)
            ffba_pkg::REQ_ALLOC: begin
                d_status = a_status;
                if (a_ok) begin
                    d_give  = 1'b1;
                    d_idx   = a_idx;
                    d_off   = a_off;
                    d_reuse = a_reuse;
                    d_take  = a_reuse;
                    d_new   = a_new;
                end
            end
            ffba_pkg::REQ_FREE: begin
                if (r_has) begin
                    if (!r_hvalid) begin
                        d_status = ffba_pkg::STAT_BADHNDL;
                    end else begin
                        d_give = 1'b1;
                        d_idx  = r_hnd_idx;
                        d_off  = i_tail.hnd_offset;
                        d_free = !i_tail.hnd_free;
                    end
                end
            end
            ffba_pkg::REQ_REALLOC: begin
                if (size_bad) begin
                    d_status = ffba_pkg::STAT_SIZE;
                end else if (r_has && !r_hvalid) begin
                    d_status = ffba_pkg::STAT_BADHNDL;
                end else if (r_has && (i_tail.hnd_size >= r_size)) begin
                    d_give = 1'b1;
                    d_idx  = r_hnd_idx;
                    d_off  = i_tail.hnd_offset;
                end else begin
                    d_status = a_status;
                    if (a_ok) begin
                        d_give  = 1'b1;
                        d_idx   = a_idx;
                        d_off   = a_off;
                        d_reuse = a_reuse;
                        d_take  = a_reuse;
                        d_new   = a_new;
                        if (r_has) begin
                            d_copy = i_tail.hnd_size;
                            d_free = !i_tail.hnd_free;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_tail.valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_launch       <= 1'b0;
            r_done         <= 1'b0;
            r_max_request  <= ffba_pkg::MAX_REQUEST_RST;
            r_heap_limit   <= ffba_pkg::HEAP_LIMIT_RST;
            r_header_bytes <= ffba_pkg::HEADER_BYTES_RST;
            r_count        <= '0;
            r_heap_top     <= '0;
            r_free_blocks  <= '0;
            r_free_bytes   <= '0;
            r_alloc_bytes  <= '0;
        end else begin
            r_state  <= n_state;
            r_launch <= accept;
            r_done   <= fire;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ffba_pkg::CFG_MAX_REQUEST:  r_max_request  <= i_cfg_data[SW-1:0];
                    ffba_pkg::CFG_HEAP_LIMIT:   r_heap_limit   <= i_cfg_data[AW-1:0];
                    ffba_pkg::CFG_HEADER_BYTES: r_header_bytes <= i_cfg_data[ffba_pkg::HDR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (fire) begin
                r_free_blocks <= r_free_blocks + CW'(d_free) - CW'(d_take);
                r_free_bytes  <= r_free_bytes
                               + (d_free ? AW'(i_tail.hnd_size) : '0)
                               - (d_take ? AW'(i_tail.fit_size) : '0);
                if (d_new) begin
                    r_count       <= r_count + CW'(1);
                    r_heap_top    <= end_sum[AW-1:0];
                    r_alloc_bytes <= r_alloc_bytes + AW'(r_size);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type    <= i_req_type;
            r_size    <= i_req_size;
            r_has     <= i_has_block;
            r_hvalid  <= i_has_block && (32'(i_block_index) < 32'(r_count));
            r_hnd_idx <= IW'(i_block_index);
        end
        if (fire) begin
            r_status <= d_status;
            r_idx    <= d_give ? d_idx : '0;
            r_off    <= d_give ? d_off : '0;
            r_reuse  <= d_give && d_reuse;
            r_copy   <= d_give ? d_copy : '0;
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_head       = '0;
        o_head.valid = r_launch;
    end

    assign o_req.size   = r_size;
    assign o_req.hnd_en = r_hvalid;
    assign o_hnd_idx    = r_hnd_idx;
    assign o_count      = r_count;
    assign o_take_idx   = i_tail_idx;

    assign o_wr.new_en     = fire && d_new;
    assign o_wr.new_size   = r_size;
    assign o_wr.new_offset = a_off;
    assign o_wr.take_en    = fire && d_take;
    assign o_wr.free_en    = fire && d_free;

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_result_index   = ffba_pkg::HNDL_W'(r_idx);
    assign o_payload_offset = r_off;
    assign o_reused         = r_reuse;
    assign o_copy_bytes     = r_copy;
    assign o_free_blocks    = ffba_pkg::CNT_W'(r_free_blocks);
    assign o_free_bytes     = r_free_bytes;
    assign o_alloc_blocks   = ffba_pkg::CNT_W'(r_count);
    assign o_alloc_bytes    = r_alloc_bytes;

    `FFBA_ASSERT_IMP(a_tail_in_scan, i_clk, i_rst_n, i_tail.valid, r_state == ST_SCAN, "token out of chain outside a scan")
    `FFBA_ASSERT_IMP(a_done_after_fire, i_clk, i_rst_n, r_done, $past(r_state == ST_SCAN) && $past(i_tail.valid), "result strobe without a finished scan")
    `FFBA_ASSERT_ALW(a_count_bound, i_clk, i_rst_n, r_count <= FULL, "block count beyond table size")
    `FFBA_ASSERT_ALW(a_free_le_count, i_clk, i_rst_n, r_free_blocks <= r_count, "more free blocks than blocks")
    `FFBA_ASSERT_IMP(a_take_free_apart, i_clk, i_rst_n, o_wr.take_en && o_wr.free_en, i_tail_idx != r_hnd_idx, "reused block is also being freed")

endmodule

// ===== sv/first_fit_block_allocator_top.sv =====
// top level of the first-fit block allocator: sequencer plus a chain of table cells
// depends on ffba_pkg, ffba_ctrl and ffba_cell
//
// channel   direction  handshake                 payload
// request   in         start, busy               i_req_type i_req_size i_block_index i_has_block
// result    out        o_done (one-cycle strobe) o_status ... o_alloc_bytes
// config    in         i_cfg_valid, o_cfg_ready  i_cfg_index i_cfg_data
//
// one request at a time, none taken while busy: a search token walks the cell chain one
// cell per cycle, then the sequencer decides and updates the table
// o_done is registered after the start transfer has passed the launch register and every
// cell of the chain; busy is low again in the o_done cycle, so the next request may be
// taken at the edge that ends it
// reset clears counters, config (to defaults) and the token; table entries are not
// cleared, the block count marks which ones hold data
// the result cannot be stalled, it is valid for exactly the o_done cycle
module first_fit_block_allocator_top #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ffba_pkg::TYPE_W-1:0]   i_req_type,
    input  logic [ffba_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [ffba_pkg::HNDL_W-1:0]   i_block_index,
    input  logic                          i_has_block,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ffba_pkg::CFGI_W-1:0]   i_cfg_index,
    input  logic [ffba_pkg::CFGD_W-1:0]   i_cfg_data,
    output logic                          o_done,
    output logic [ffba_pkg::STAT_W-1:0]   o_status,
    output logic [ffba_pkg::HNDL_W-1:0]   o_result_index,
    output logic [ffba_pkg::ADDR_W-1:0]   o_payload_offset,
    output logic                          o_reused,
    output logic [ffba_pkg::SIZE_W-1:0]   o_copy_bytes,
    output logic [ffba_pkg::CNT_W-1:0]    o_free_blocks,
    output logic [ffba_pkg::ADDR_W-1:0]   o_free_bytes,
    output logic [ffba_pkg::CNT_W-1:0]    o_alloc_blocks,
    output logic [ffba_pkg::ADDR_W-1:0]   o_alloc_bytes
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS+1);

    // token links: link 0 is the launch from the sequencer, the last link returns to it
    ffba_pkg::t_tok tok_link [MAX_BLOCKS+1];
    logic [IW-1:0]  idx_link [MAX_BLOCKS+1];

    // broadcast to every cell
    ffba_pkg::t_req req;
    ffba_pkg::t_wr  wr;
    logic [IW-1:0]  hnd_idx;
    logic [IW-1:0]  take_idx;
    logic [CW-1:0]  count;

    assign idx_link[0] = '0;

    ffba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_req_type       (i_req_type),
        .i_req_size       (i_req_size),
        .i_block_index    (i_block_index),
        .i_has_block      (i_has_block),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_head           (tok_link[0]),
        .o_req            (req),
        .o_hnd_idx        (hnd_idx),
        .o_count          (count),
        .o_wr             (wr),
        .o_take_idx       (take_idx),
        .i_tail           (tok_link[MAX_BLOCKS]),
        .i_tail_idx       (idx_link[MAX_BLOCKS]),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_result_index   (o_result_index),
        .o_payload_offset (o_payload_offset),
        .o_reused         (o_reused),
        .o_copy_bytes     (o_copy_bytes),
        .o_free_blocks    (o_free_blocks),
        .o_free_bytes     (o_free_bytes),
        .o_alloc_blocks   (o_alloc_blocks),
        .o_alloc_bytes    (o_alloc_bytes)
    );

    // one cell per table entry, in creation order
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffba_cell #(
            .MAX_BLOCKS (MAX_BLOCKS),
            .CELL_ID    (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (tok_link[g]),
            .i_fit_idx  (idx_link[g]),
            .o_tok      (tok_link[g+1]),
            .o_fit_idx  (idx_link[g+1]),
            .i_req      (req),
            .i_hnd_idx  (hnd_idx),
            .i_count    (count),
            .i_wr       (wr),
            .i_take_idx (take_idx)
        );
    end

endmodule
